@@ rtl/mdiv_pkg.sv @@
// Package for mul_div_128: operand widths, pipeline depth and the
// restoring-division step shared by the divider stages. No dependencies.
`default_nettype none
package mdiv_pkg;

  localparam int unsigned W      = 64;
  localparam int unsigned HALF   = W / 2;
  localparam int unsigned NDIV   = W;          // one quotient bit per stage
  localparam int unsigned STEP_W = W + 1;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [STEP_W-1:0] div_step(input logic [W-1:0] rem,
                                                 input logic         nbit,
                                                 input logic [W-1:0] den);
    logic [W:0] sh;
    logic [W:0] dx;
    logic [W:0] df;
    logic       ge;
    sh = {rem, nbit};
    dx = {1'b0, den};
    df = sh - dx;
    ge = (sh >= dx);
    return ge ? {1'b1, df[W-1:0]} : {1'b0, sh[W-1:0]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/mul_div_128.sv @@
// mul_div_128: 64x64 widening multiply, then 128-by-64 restoring divide.
// Pipeline: the partial-product stage forms the four 32x32 products, the
// column-sum stage adds them, then one quotient bit per stage over 64 divider stages.
// Throughput one item per cycle; the whole pipe holds while a result stalls.
// Reset (rst_n low, synchronous) clears the stage valid bits only.
// Depends on mdiv_pkg.
`default_nettype none
module mul_div_128 (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [191:0] in_tdata,   // multiplicand, multiplier, divisor
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // product_low, product_high, quotient
  output logic [1:0]        out_tuser   // product_wide, overflow
);

  localparam int unsigned W    = mdiv_pkg::W;
  localparam int unsigned HALF = mdiv_pkg::HALF;
  localparam int unsigned NDIV = mdiv_pkg::NDIV;

  logic adv;

  // Partial-product stage
  logic           v0_r;
  logic [W-1:0]   pll_r, plh_r, phl_r, phh_r, d0_r;
  // Column-sum stage
  logic           v1_r;
  logic [W-1:0]   lo1_r, hi1_r, d1_r;
  // Divider stages
  logic [NDIV-1:0] dv_r;
  logic [W-1:0]    rem_r [NDIV];
  logic [W-1:0]    lsh_r [NDIV];
  logic [W-1:0]    q_r   [NDIV];
  logic [W-1:0]    d_r   [NDIV];
  logic [W-1:0]    plo_r [NDIV];
  logic [W-1:0]    phi_r [NDIV];
  logic            wide_r[NDIV];
  logic            ovf_r [NDIV];

  logic [W-1:0]    rem_nxt [NDIV];
  logic [W-1:0]    lsh_nxt [NDIV];
  logic [W-1:0]    q_nxt   [NDIV];

  logic [W-1:0] a_in, b_in, d_in;
  logic [W-1:0] mid, lo1_nxt, hi1_nxt;

  assign a_in = in_tdata[W-1:0];
  assign b_in = in_tdata[2*W-1:W];
  assign d_in = in_tdata[3*W-1:2*W];

  assign out_tvalid = dv_r[NDIV-1];
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;

  assign mid     = {32'd0, pll_r[W-1:HALF]} + {32'd0, plh_r[HALF-1:0]}
                 + {32'd0, phl_r[HALF-1:0]};
  assign lo1_nxt = {mid[HALF-1:0], pll_r[HALF-1:0]};
  assign hi1_nxt = phh_r + {32'd0, plh_r[W-1:HALF]} + {32'd0, phl_r[W-1:HALF]}
                 + {32'd0, mid[W-1:HALF]};

  always_comb begin
    logic [W-1:0] rin, lin, qin;
    logic [W:0]   st;
    for (int k = 0; k < NDIV; k++) begin
      if (k == 0) begin
        rin = hi1_r;
        lin = lo1_r;
        qin = '0;
      end else begin
        rin = rem_r[k-1];
        lin = lsh_r[k-1];
        qin = q_r[k-1];
      end
      st = mdiv_pkg::div_step(rin, lin[W-1], (k == 0) ? d1_r : d_r[k-1]);
      rem_nxt[k] = st[W-1:0];
      lsh_nxt[k] = {lin[W-2:0], 1'b0};
      q_nxt[k]   = {qin[W-2:0], st[W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      dv_r <= '0;
    end else if (adv) begin
      v0_r <= in_tvalid;
      v1_r <= v0_r;
      dv_r <= {dv_r[NDIV-2:0], v1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pll_r <= a_in[HALF-1:0] * b_in[HALF-1:0];
      plh_r <= a_in[HALF-1:0] * b_in[W-1:HALF];
      phl_r <= a_in[W-1:HALF] * b_in[HALF-1:0];
      phh_r <= a_in[W-1:HALF] * b_in[W-1:HALF];
      d0_r  <= d_in;
      lo1_r <= lo1_nxt;
      hi1_r <= hi1_nxt;
      d1_r  <= d0_r;
      for (int k = 0; k < NDIV; k++) begin
        rem_r[k] <= rem_nxt[k];
        lsh_r[k] <= lsh_nxt[k];
        q_r[k]   <= q_nxt[k];
        if (k == 0) begin
          d_r[k]    <= d1_r;
          plo_r[k]  <= lo1_r;
          phi_r[k]  <= hi1_r;
          wide_r[k] <= (hi1_r[W-1:HALF] != '0);
          ovf_r[k]  <= (hi1_r[W-1:HALF] != '0) || (hi1_r >= d1_r);
        end else begin
          d_r[k]    <= d_r[k-1];
          plo_r[k]  <= plo_r[k-1];
          phi_r[k]  <= phi_r[k-1];
          wide_r[k] <= wide_r[k-1];
          ovf_r[k]  <= ovf_r[k-1];
        end
      end
    end
  end

  assign out_tdata = {(ovf_r[NDIV-1] ? {W{1'b1}} : q_r[NDIV-1]),
                      phi_r[NDIV-1], plo_r[NDIV-1]};
  assign out_tuser = {ovf_r[NDIV-1], wide_r[NDIV-1]};

endmodule
`default_nettype wire

@@ dv/mul_div_128_checker.sv @@
// Checker for mul_div_128: watches the input and result streams, predicts each
// result with a 128-bit multiply and divide, and counts mismatches. Uses mdiv_pkg.
`default_nettype none
module mul_div_128_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [191:0] in_tdata,   // multiplicand, multiplier, divisor
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [191:0] out_tdata,  // product_low, product_high, quotient
  input  wire logic [1:0]   out_tuser,  // product_wide, overflow
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mdiv_pkg::W-1:0] quotient;
    logic [mdiv_pkg::W-1:0] prod_hi;
    logic [mdiv_pkg::W-1:0] prod_lo;
    logic                   overflow;
    logic                   wide;
  } muldiv_res_t;

  muldiv_res_t expected_q[$];

  function automatic muldiv_res_t compute_muldiv(logic [mdiv_pkg::W-1:0] a,
                                                 logic [mdiv_pkg::W-1:0] b,
                                                 logic [mdiv_pkg::W-1:0] d);
    muldiv_res_t r;
    logic [2*mdiv_pkg::W-1:0] p;
    logic [2*mdiv_pkg::W-1:0] q;
    p = {{mdiv_pkg::W{1'b0}}, a} * {{mdiv_pkg::W{1'b0}}, b};
    r.prod_lo = p[mdiv_pkg::W-1:0];
    r.prod_hi = p[2*mdiv_pkg::W-1:mdiv_pkg::W];
    r.wide = (r.prod_hi[mdiv_pkg::W-1:mdiv_pkg::HALF] != '0);
    r.overflow = r.wide || (r.prod_hi >= d);
    if (r.overflow) begin
      r.quotient = '1;
    end else begin
      q = p / {{mdiv_pkg::W{1'b0}}, d};
      r.quotient = q[mdiv_pkg::W-1:0];
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    muldiv_res_t e;
    if (!rst_n) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $error("result with no item pending: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[63:0] !== e.prod_lo || out_tdata[127:64] !== e.prod_hi ||
              out_tdata[191:128] !== e.quotient || out_tuser[0] !== e.wide ||
              out_tuser[1] !== e.overflow)
            fail_count <= fail_count + 1;
          if (out_tdata[63:0] !== e.prod_lo)
            $error("product_low exp %h got %h", e.prod_lo, out_tdata[63:0]);
          if (out_tdata[127:64] !== e.prod_hi)
            $error("product_high exp %h got %h", e.prod_hi, out_tdata[127:64]);
          if (out_tdata[191:128] !== e.quotient)
            $error("quotient exp %h got %h", e.quotient, out_tdata[191:128]);
          if (out_tuser[0] !== e.wide)
            $error("product_wide exp %b got %b", e.wide, out_tuser[0]);
          if (out_tuser[1] !== e.overflow)
            $error("overflow exp %b got %b", e.overflow, out_tuser[1]);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(compute_muldiv(in_tdata[63:0], in_tdata[127:64],
                                            in_tdata[191:128]));
    end
  end
endmodule
`default_nettype wire

@@ dv/mul_div_128_tb.sv @@
// Top of the mul_div_128 testbench: clock, reset, directed and random operands,
// random stalls on both streams, verdict. Uses mul_div_128_checker and mdiv_pkg.
`default_nettype none
module mul_div_128_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 700;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic [1:0]   out_tuser;
  int           fail_count;
  int           pending;
  bit           calm = 1'b0;   // no idling on either side
  bit           hold_sink = 1'b0;
  int           idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  mul_div_128 u_top (.*);

  mul_div_128_checker u_chk (.*);

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mix of full-range, small and boundary operands.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return rand64();
      1: return 64'($urandom());
      2: return 64'($urandom_range(0, 3));
      3: return '1 - 64'($urandom_range(0, 3));
      4: return rand64() >> $urandom_range(0, 63);
      default: return 64'(1) << $urandom_range(0, 63);
    endcase
  endfunction

  task automatic send_item(logic [63:0] a, logic [63:0] b, logic [63:0] d);
    while (!calm && $urandom_range(0, 99) < 22) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {d, b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Build operands so that the product's high half lies below the divisor.
  task automatic send_fitting();
    logic [63:0] a, b, d;
    logic [127:0] p;
    a = pick_operand();
    b = 64'($urandom()) >> $urandom_range(0, 31);
    p = a * b;
    d = p[127:64] + 64'(1) + (rand64() >> $urandom_range(0, 63));
    if (d <= p[127:64]) d = '1;
    send_item(a, b, d);
  endtask

  // Receiver: random stalls, plus a long forced hold-off.
  always @(posedge clk) begin
    if (!rst_n || hold_sink) out_tready <= 1'b0;
    else out_tready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // extremes, zero divisor, wide product, large divisors
    send_item('0, '0, '0);
    send_item('0, '0, 64'd1);
    send_item('1, '1, '1);
    send_item('1, '1, '0);
    send_item('1, 64'd1, '1);
    send_item(64'd1, 64'd1, 64'd1);
    send_item(64'hFFFF_FFFF, 64'hFFFF_FFFF, 64'd3);
    send_item('1, 64'h1_0000_0000, 64'h1_0000_0001);
    send_item(64'h1_0000_0000, 64'h1_0000_0000, 64'h2);
    send_item('1, 64'h7FFF_FFFF, 64'h8000_0000);
    send_item('1, 64'hFFFF_FFFF, 64'h1_0000_0000);
    send_item(64'h8000_0000_0000_0000, 64'h2, 64'h2);
    send_item(64'h8000_0000_0000_0000, 64'h2, 64'h1);
    send_item('1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(64'h1234_5678_9ABC_DEF0, 64'hFFFF_FFFF, 64'hFFFF_FFFF_0000_0001);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555, 64'h8000_0000_0000_0000);
    send_item(64'h5555_5555_5555_5555, 64'h5555_5555, '0);
    // long stretch without idling
    calm = 1'b1;
    repeat (60) send_fitting();
    calm = 1'b0;
    // sink holds off while the source keeps offering items
    fork
      begin
        hold_sink = 1'b1;
        repeat (200) @(posedge clk);
        hold_sink = 1'b0;
      end
      repeat (120) send_fitting();
    join
    for (int i = 0; i < RANDOM_ITEMS - 180; i++) begin
      if ($urandom_range(0, 99) < 70) send_fitting();
      else send_item(pick_operand(), pick_operand(), pick_operand());
    end
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
